// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/dpq_pkg.sv -----
// Package: types, constants and codes of the double-ended priority queue.
`default_nettype none

package dpq_pkg;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned ID_W       = 31;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned GROUP_SIZE = 32;
  localparam int unsigned NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned PAD_CELLS  = NUM_GROUPS * GROUP_SIZE;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_POP_MAX = 2'd1,
    ACT_POP_MIN = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INC,
    OP_DEC,
    OP_INSERT,
    OP_SHIFT_DOWN,
    OP_CLR_TOP
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RED1,
    S_RED2,
    S_APPLY
  } state_e;

  typedef struct packed {
    action_e                  action;
    logic [ID_W-1:0]          client_id;
    logic signed [KEY_W-1:0]  priority_key;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] popped_id;
    status_e         status;
  } out_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                    valid;
    logic                    lt;
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         id;
    logic [CNT_W-1:0]        count;
  } cell_t;

  // Contribution of the selected cell to the reduction tree.
  typedef struct packed {
    logic            hit;
    logic            sat;
    logic            one;
    logic [ID_W-1:0] id;
  } red_t;

  // Broadcast update command.
  typedef struct packed {
    op_e                     op;
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         id;
  } apply_t;

  localparam cell_t CELL_LO = '{valid: 1'b0, lt: 1'b1, key: '0, id: '0, count: '0};
  localparam cell_t CELL_HI = '{valid: 1'b0, lt: 1'b0, key: '0, id: '0, count: '0};
  localparam red_t  RED_ZERO = '{hit: 1'b0, sat: 1'b0, one: 1'b0, id: '0};

endpackage

`default_nettype wire

// ----- rtl/core/double_ended_priority_queue_core.sv -----
// Top level: sorted cell-row double-ended priority queue with valid/ready channels.
// The result is registered after the input beat is accepted, through flag latch on
//   accept, two registered reduction levels, then apply + output register.
// A new beat is accepted only in IDLE, after the reduction tree over the cell row
//   and the single apply pass for the previous beat; APPLY waits for a free output register.
// Reset: rst_ni clears the control FSM, output valid and every cell's valid bit;
//   the store is empty at once, no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module double_ended_priority_queue_core (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  dpq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output dpq_pkg::out_t  out_data_o
);

  localparam int unsigned VEXT_W = dpq_pkg::CAPACITY + 1;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  dpq_pkg::state_e state_q, state_d;
  dpq_pkg::in_t    cmd_q;            // held beat for the apply step
  logic            out_valid_q, out_valid_d;
  dpq_pkg::out_t   out_q, out_d;
  dpq_pkg::red_t   tot_q, tot_d;     // final reduction level
  dpq_pkg::apply_t apply;

  logic in_fire;
  logic out_free;
  logic apply_fire;

  assign in_ready_o = (state_q == dpq_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign apply_fire = (state_q == dpq_pkg::S_APPLY) && out_free;

  // ---------------------------------------------------------------------------
  // Cell row. Slot 0 holds the smallest key; occupied slots are contiguous.
  // ---------------------------------------------------------------------------
  dpq_pkg::cell_t chain     [dpq_pkg::CAPACITY];
  dpq_pkg::red_t  cell_red  [dpq_pkg::PAD_CELLS];
  dpq_pkg::red_t  grp_red   [dpq_pkg::NUM_GROUPS];
  logic [dpq_pkg::CAPACITY-1:0] valid_vec;
  logic [dpq_pkg::CAPACITY-1:0] sel_vec;

  for (genvar gi = 0; gi < dpq_pkg::CAPACITY; gi++) begin : g_cell
    dpq_pkg::cell_t prev_c;
    dpq_pkg::cell_t next_c;

    if (gi == 0) begin : g_lo
      assign prev_c = dpq_pkg::CELL_LO;   // lt=1 marks slot 0 as a legal insert point
    end else begin : g_mid_lo
      assign prev_c = chain[gi-1];
    end

    if (gi == dpq_pkg::CAPACITY - 1) begin : g_hi
      assign next_c = dpq_pkg::CELL_HI;   // shifts in an empty slot at the top
    end else begin : g_mid_hi
      assign next_c = chain[gi+1];
    end

    dpq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (in_fire),
      .in_i    (in_data_i),
      .apply_i (apply),
      .prev_i  (prev_c),
      .next_i  (next_c),
      .self_o  (chain[gi]),
      .red_o   (cell_red[gi])
    );

    assign valid_vec[gi] = chain[gi].valid;
    assign sel_vec[gi]   = cell_red[gi].hit;
  end

  // unused tail of the last group contributes nothing
  for (genvar gp = dpq_pkg::CAPACITY; gp < dpq_pkg::PAD_CELLS; gp++) begin : g_pad
    assign cell_red[gp] = dpq_pkg::RED_ZERO;
  end

  // ---------------------------------------------------------------------------
  // Two-level reduction: per group, then across groups.
  // Gives hit (some slot selected), sat/one (its count) and its id.
  // ---------------------------------------------------------------------------
  for (genvar gg = 0; gg < dpq_pkg::NUM_GROUPS; gg++) begin : g_grp
    dpq_pkg::red_t part [dpq_pkg::GROUP_SIZE];
    for (genvar gk = 0; gk < dpq_pkg::GROUP_SIZE; gk++) begin : g_part
      assign part[gk] = cell_red[gg * dpq_pkg::GROUP_SIZE + gk];
    end
    dpq_reduce u_reduce (
      .clk_i  (clk_i),
      .load_i (state_q == dpq_pkg::S_RED1),
      .part_i (part),
      .sum_o  (grp_red[gg])
    );
  end

  always_comb begin
    tot_d = dpq_pkg::RED_ZERO;
    for (int unsigned g = 0; g < dpq_pkg::NUM_GROUPS; g++) begin
      tot_d = tot_d | grp_red[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dpq_pkg::S_RED2) tot_q <= tot_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) cmd_q <= in_data_i;
  end

  // ---------------------------------------------------------------------------
  // FSM: IDLE (accept, cells latch compare flags) -> RED1 -> RED2 -> APPLY.
  // APPLY waits until the output register is free.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    apply       = '{op: dpq_pkg::OP_NONE, key: cmd_q.priority_key, id: cmd_q.client_id};

    unique case (state_q)
      dpq_pkg::S_IDLE: begin
        if (in_fire) state_d = dpq_pkg::S_RED1;
      end
      dpq_pkg::S_RED1: state_d = dpq_pkg::S_RED2;
      dpq_pkg::S_RED2: state_d = dpq_pkg::S_APPLY;
      dpq_pkg::S_APPLY: begin
        if (out_free) begin
          state_d           = dpq_pkg::S_IDLE;
          out_valid_d       = 1'b1;
          out_d.popped_id   = '0;
          out_d.status      = dpq_pkg::ST_DONE;
          case (cmd_q.action) inside
            dpq_pkg::ACT_INSERT: begin
              if (tot_q.hit) begin
                // key present: bump count unless saturated
                if (tot_q.sat) out_d.status = dpq_pkg::ST_FULL;
                else           apply.op     = dpq_pkg::OP_INC;
              end else if (valid_vec[dpq_pkg::CAPACITY-1]) begin
                out_d.status = dpq_pkg::ST_FULL;
              end else begin
                apply.op = dpq_pkg::OP_INSERT;
              end
            end
            dpq_pkg::ACT_POP_MAX, dpq_pkg::ACT_POP_MIN: begin
              if (!tot_q.hit) begin
                out_d.status = dpq_pkg::ST_EMPTY;
              end else begin
                out_d.popped_id = tot_q.id;
                if (!tot_q.one)                               apply.op = dpq_pkg::OP_DEC;
                else if (cmd_q.action == dpq_pkg::ACT_POP_MAX) apply.op = dpq_pkg::OP_CLR_TOP;
                else                                          apply.op = dpq_pkg::OP_SHIFT_DOWN;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = dpq_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic [VEXT_W-1:0] valid_ext;
  assign valid_ext = {1'b0, valid_vec};

  // a result only appears from the apply step
  `ASSERT_IMPL(a_out_from_apply, $rose(out_valid_q), $past(state_q) == dpq_pkg::S_APPLY)
  // at most one slot is selected outside IDLE
  `ASSERT_IMPL(a_sel_onehot, state_q != dpq_pkg::S_IDLE, $onehot0(sel_vec))
  // occupied slots stay packed at the bottom of the row
  `ASSERT_IMPL(a_row_packed, 1'b1, $onehot(valid_ext + VEXT_W'(1)))
  // an empty-pop answer only when slot 0 is empty
  `ASSERT_IMPL(a_empty_pop, apply_fire && out_d.status == dpq_pkg::ST_EMPTY, !valid_vec[0])

endmodule

`default_nettype wire

// ----- rtl/core/dpq_cell.sv -----
// One slot of the sorted cell row.
`default_nettype none

module dpq_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  dpq_pkg::in_t         in_i,
  input  dpq_pkg::apply_t      apply_i,
  input  dpq_pkg::cell_t       prev_i,
  input  dpq_pkg::cell_t       next_i,
  output dpq_pkg::cell_t       self_o,
  output dpq_pkg::red_t        red_o
);

  logic                              valid_q, valid_d;
  logic signed [dpq_pkg::KEY_W-1:0]  key_q, key_d;
  logic [dpq_pkg::ID_W-1:0]          id_q, id_d;
  logic [dpq_pkg::CNT_W-1:0]         count_q, count_d;
  logic                              lt_q, lt_d;
  logic                              sel_q, sel_d;

  // compare/select flags, latched on the accept edge
  always_comb begin
    lt_d  = lt_q;
    sel_d = sel_q;
    if (start_i) begin
      lt_d = valid_q && (key_q < in_i.priority_key);
      case (in_i.action)
        dpq_pkg::ACT_INSERT:  sel_d = valid_q && (key_q == in_i.priority_key);
        dpq_pkg::ACT_POP_MAX: sel_d = valid_q && !next_i.valid;
        dpq_pkg::ACT_POP_MIN: sel_d = valid_q && !prev_i.valid;
        default:              sel_d = 1'b0;
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    id_d    = id_q;
    count_d = count_q;
    case (apply_i.op)
      dpq_pkg::OP_INC: begin
        if (sel_q) count_d = count_q + dpq_pkg::CNT_ONE;
      end
      dpq_pkg::OP_DEC: begin
        if (sel_q) count_d = count_q - dpq_pkg::CNT_ONE;
      end
      dpq_pkg::OP_CLR_TOP: begin
        if (sel_q) valid_d = 1'b0;
      end
      dpq_pkg::OP_SHIFT_DOWN: begin
        valid_d = next_i.valid;
        key_d   = next_i.key;
        id_d    = next_i.id;
        count_d = next_i.count;
      end
      dpq_pkg::OP_INSERT: begin
        if (!lt_q) begin
          if (prev_i.lt) begin
            // insertion point
            valid_d = 1'b1;
            key_d   = apply_i.key;
            id_d    = apply_i.id;
            count_d = dpq_pkg::CNT_ONE;
          end else begin
            valid_d = prev_i.valid;
            key_d   = prev_i.key;
            id_d    = prev_i.id;
            count_d = prev_i.count;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      lt_q    <= lt_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    id_q    <= id_d;
    count_q <= count_d;
  end

  assign self_o = '{valid: valid_q, lt: lt_q, key: key_q, id: id_q, count: count_q};

  assign red_o.hit = sel_q;
  assign red_o.sat = sel_q && (count_q == dpq_pkg::CNT_MAX);
  assign red_o.one = sel_q && (count_q == dpq_pkg::CNT_ONE);
  assign red_o.id  = sel_q ? id_q : '0;

endmodule

`default_nettype wire

// ----- rtl/core/dpq_reduce.sv -----
// Registered OR reduction of one group of cell contributions.
`default_nettype none

module dpq_reduce (
  input  wire logic     clk_i,
  input  wire logic     load_i,
  input  dpq_pkg::red_t part_i [dpq_pkg::GROUP_SIZE],
  output dpq_pkg::red_t sum_o
);

  dpq_pkg::red_t sum_d, sum_q;

  always_comb begin
    sum_d = dpq_pkg::RED_ZERO;
    for (int unsigned k = 0; k < dpq_pkg::GROUP_SIZE; k++) begin
      sum_d = sum_d | part_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire
